FILE: hw/rtl/manchester_symbol_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// Manchester symbol decoder assertion macros
// Shared property shorthands for the decoder's checkers.
// ---------------------------------------------------------------------------
`ifndef MANCHESTER_SYMBOL_DECODER_UNIT_DEFINES_SVH
`define MANCHESTER_SYMBOL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/msd_pkg.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder package
// Types, register indexes and reset values shared by the decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msd_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PAUSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PAUSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FIRST = 3'd4;

  // Register reset values
  localparam logic [CODE_W-1:0] SHORT_PAUSE_RST = 8'd97;
  localparam logic [CODE_W-1:0] LONG_PAUSE_RST  = 8'd98;
  localparam logic [CODE_W-1:0] SHORT_PULSE_RST = 8'd65;
  localparam logic [CODE_W-1:0] LONG_PULSE_RST  = 8'd66;
  localparam logic              PULSE_FIRST_RST = 1'b1;

  typedef enum logic [1:0] {
    PH_START_PULSE = 2'd0,
    PH_START_PAUSE = 2'd1,
    PH_MID_PULSE   = 2'd2,
    PH_MID_PAUSE   = 2'd3
  } phase_t;

  // One decoded result beat
  typedef struct packed {
    logic bit_value;
    logic bit_valid;
    logic decode_error;
    logic packet_end;
  } result_t;

  // Front to queue push
  typedef struct packed {
    logic    push;
    result_t data;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic    avail;
    result_t data;
  } pop_t;

endpackage

FILE: hw/rtl/msd_front.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder front end
// Holds the configuration registers, classifies each symbol and runs the
// four-phase Manchester machine; pushes one result per bit, error or end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msd_pkg::CODE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [msd_pkg::CODE_W-1:0]       in_symbol,
  input  logic                             in_last_symbol,
  input  logic                             q_full,
  output msd_pkg::push_t                   push
);
  import msd_pkg::*;

  logic [CODE_W-1:0] short_pause_r;
  logic [CODE_W-1:0] long_pause_r;
  logic [CODE_W-1:0] short_pulse_r;
  logic [CODE_W-1:0] long_pulse_r;
  logic              pulse_first_r;

  phase_t phase_r, phase_nxt;
  logic   err_r, err_nxt;

  logic is_spause, is_lpause, is_spulse, is_lpulse;
  logic accept;
  logic have_bit, bit_val, bad;
  logic restart_cfg;

  assign in_stall    = q_full;
  assign accept      = in_valid && !q_full;
  assign restart_cfg = cfg_we && (cfg_index == CFG_PULSE_FIRST);

  assign is_spause = (in_symbol == short_pause_r);
  assign is_lpause = (in_symbol == long_pause_r);
  assign is_spulse = (in_symbol == short_pulse_r);
  assign is_lpulse = (in_symbol == long_pulse_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_pause_r <= SHORT_PAUSE_RST;
      long_pause_r  <= LONG_PAUSE_RST;
      short_pulse_r <= SHORT_PULSE_RST;
      long_pulse_r  <= LONG_PULSE_RST;
      pulse_first_r <= PULSE_FIRST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_PAUSE: short_pause_r <= cfg_data;
        CFG_LONG_PAUSE:  long_pause_r  <= cfg_data;
        CFG_SHORT_PULSE: short_pulse_r <= cfg_data;
        CFG_LONG_PULSE:  long_pulse_r  <= cfg_data;
        CFG_PULSE_FIRST: pulse_first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next phase and error flag
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    if (restart_cfg) begin
      phase_nxt = cfg_data[0] ? PH_START_PULSE : PH_START_PAUSE;
      err_nxt   = 1'b0;
    end else if (accept) begin
      if (!err_r) begin
        unique case (phase_r)
          PH_START_PULSE: begin
            if (is_spulse) phase_nxt = PH_MID_PAUSE;
            else           err_nxt   = 1'b1;
          end
          PH_START_PAUSE: begin
            if (is_spause) phase_nxt = PH_MID_PULSE;
            else           err_nxt   = 1'b1;
          end
          PH_MID_PULSE: begin
            if (is_spulse)      phase_nxt = PH_START_PAUSE;
            else if (is_lpulse) phase_nxt = PH_MID_PAUSE;
            else                err_nxt   = 1'b1;
          end
          PH_MID_PAUSE: begin
            if (is_spause)      phase_nxt = PH_START_PULSE;
            else if (is_lpause) phase_nxt = PH_MID_PULSE;
            else                err_nxt   = 1'b1;
          end
          default: ;
        endcase
      end
      // restart after the packet's final symbol, even one that broke it
      if (in_last_symbol) begin
        phase_nxt = pulse_first_r ? PH_START_PULSE : PH_START_PAUSE;
        err_nxt   = 1'b0;
      end
    end
  end

  // Bit and error outputs of the current phase
  always_comb begin
    have_bit = 1'b0;
    bit_val  = 1'b0;
    bad      = 1'b0;
    if (!err_r) begin
      unique case (phase_r)
        PH_START_PULSE: begin
          if (is_spulse) begin
            have_bit = 1'b1;
            bit_val  = pulse_first_r;
          end else begin
            bad = 1'b1;
          end
        end
        PH_START_PAUSE: begin
          if (is_spause) begin
            have_bit = 1'b1;
            bit_val  = !pulse_first_r;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MID_PULSE: begin
          if (is_spulse) begin
            have_bit = 1'b0;
          end else if (is_lpulse) begin
            have_bit = 1'b1;
            bit_val  = pulse_first_r;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MID_PAUSE: begin
          if (is_spause) begin
            have_bit = 1'b0;
          end else if (is_lpause) begin
            have_bit = 1'b1;
            bit_val  = !pulse_first_r;
          end else begin
            bad = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START_PULSE;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
    end
  end

  // Drop symbols that yield nothing
  assign push.push              = accept && (have_bit || bad || in_last_symbol);
  assign push.data.bit_value    = have_bit && bit_val;
  assign push.data.bit_valid    = have_bit;
  assign push.data.decode_error = bad;
  assign push.data.packet_end   = in_last_symbol;

endmodule

FILE: hw/rtl/msd_queue.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder result queue
// Small first-in first-out buffer between the decoder front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  msd_pkg::push_t  push,
  output logic            full,
  input  logic            pop,
  output msd_pkg::pop_t   head
);
  import msd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push.push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign wr_ptr_nxt = !do_push ? wr_ptr_r :
                      (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_nxt = !do_pop ? rd_ptr_r :
                      (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.data;
  end

  assign head.avail = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];

endmodule

FILE: hw/rtl/msd_back.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder back end
// Output register that presents queued results on the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  msd_pkg::pop_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_bit_value,
  output logic           out_bit_valid,
  output logic           out_decode_error,
  output logic           out_packet_end
);
  import msd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;
  logic    load;

  // Refill when empty or when the held beat leaves this cycle
  assign load      = head.avail && (!valid_r || !out_stall);
  assign pop       = load;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= head.data;
  end

  assign out_valid        = valid_r;
  assign out_bit_value    = data_r.bit_value;
  assign out_bit_valid    = data_r.bit_valid;
  assign out_decode_error = data_r.decode_error;
  assign out_packet_end   = data_r.packet_end;

endmodule

FILE: hw/rtl/manchester_symbol_decoder_unit.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder unit
// Decodes short/long pulse and pause symbols into Manchester data bits.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_symbol[7:0], in_last_symbol
//   out_     out  out_valid/out_stall out_bit_value, out_bit_valid,
//                                     out_decode_error, out_packet_end
//   cfg_     in   cfg_we              cfg_index[2:0], cfg_data[7:0]
//
// One symbol a cycle is taken while in_stall is low; the phase machine updates in that cycle.
// A result passes through the queue and then the output register to reach out_valid.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Reset is synchronous: it clears the phase, the queue and the output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module manchester_symbol_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msd_pkg::CODE_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [msd_pkg::CODE_W-1:0]     in_symbol,
  input  logic                           in_last_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_bit_value,
  output logic                           out_bit_valid,
  output logic                           out_decode_error,
  output logic                           out_packet_end
);
  import msd_pkg::*;

  push_t push;
  pop_t  head;
  logic  q_full;
  logic  pop;

  msd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .q_full         (q_full),
    .push           (push)
  );

  msd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  msd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bit_value    (out_bit_value),
    .out_bit_valid    (out_bit_valid),
    .out_decode_error (out_decode_error),
    .out_packet_end   (out_packet_end)
  );

endmodule

FILE: hw/rtl/msd_checker.sv
// ---------------------------------------------------------------------------
// Manchester symbol decoder port checker
// Watches the top-level ports and flags malformed result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "manchester_symbol_decoder_unit_defines.svh"

module msd_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_bit_value,
  input logic out_bit_valid,
  input logic out_decode_error,
  input logic out_packet_end
);

  // hold a stalled beat
  `MSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_bit_value, out_bit_valid, out_decode_error, out_packet_end}), "stalled result beat changed")

  // every beat carries a bit, an error or an end mark
  `MSD_ASSERT_IMPL(a_no_empty, clk, rst_n, out_valid, out_bit_valid || out_decode_error || out_packet_end, "empty result beat")

  `MSD_ASSERT_IMPL(a_bit_zero, clk, rst_n, out_valid && !out_bit_valid, !out_bit_value, "bit value set without a bit")

  // a breaking symbol never decodes a bit
  `MSD_ASSERT_IMPL(a_err_no_bit, clk, rst_n, out_valid && out_decode_error, !out_bit_valid, "bit on an error beat")

endmodule

bind manchester_symbol_decoder_unit msd_checker u_msd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_bit_value    (out_bit_value),
  .out_bit_valid    (out_bit_valid),
  .out_decode_error (out_decode_error),
  .out_packet_end   (out_packet_end)
);
